[hdl/fpalu_pkg.sv]
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared constants, action codes and pipeline types of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

   localparam int FRACTION_BITS = 14;
   localparam int DATA_W        = 32;
   localparam int DIVIDEND_W    = DATA_W + FRACTION_BITS;
   localparam int LATENCY       = DIVIDEND_W + 2;

   typedef enum logic [3:0] {
      ACT_INT_TO_FIX       = 4'd0,
      ACT_FIX_TO_INT_TRUNC = 4'd1,
      ACT_FIX_TO_INT_ROUND = 4'd2,
      ACT_ADD_FF           = 4'd3,
      ACT_ADD_FI           = 4'd4,
      ACT_SUB_FF           = 4'd5,
      ACT_SUB_FI           = 4'd6,
      ACT_MUL_FF           = 4'd7,
      ACT_MUL_FI           = 4'd8,
      ACT_DIV_FF           = 4'd9,
      ACT_DIV_FI           = 4'd10
   } action_type;

   typedef struct packed {
      logic                  valid;
      action_type            action;
      logic signed [63:0]    product;
      logic [DATA_W-1:0]     simple;
      logic                  is_div;
      logic                  neg;
      logic                  dz;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DATA_W-1:0]     divisor;
   } prep_type;

   typedef struct packed {
      logic                  valid;
      logic                  is_div;
      logic                  neg;
      logic                  dz;
      logic [DATA_W-1:0]     value;
      logic [DATA_W-1:0]     rem;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DATA_W-1:0]     divisor;
      logic [DATA_W-1:0]     quot;
   } cell_data_type;

endpackage

[hdl/fpalu_prep.sv]
// ----------------------------------------------------------------------------
// fpalu_prep
// Two front stages: operand decode, simple results, the signed product and the
// divider set-up, then the fixed multiply truncation that feeds the chain.
// ----------------------------------------------------------------------------
module fpalu_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [3:0]                   action,
   input  logic [31:0]                  operand_a,
   input  logic [31:0]                  operand_b,
   output fpalu_pkg::cell_data_type     cell_out
);
   import fpalu_pkg::*;

   localparam logic [32:0] TRUNC_BIAS = 33'((64'd1 << FRACTION_BITS) - 64'd1);
   localparam logic [32:0] ROUND_HALF = 33'(64'd1 << (FRACTION_BITS - 1));
   localparam logic [63:0] MUL_BIAS   = (64'd1 << FRACTION_BITS) - 64'd1;

   prep_type           stage_a_ff, stage_a_in;
   cell_data_type      stage_b_ff, stage_b_in;

   logic signed [31:0] a_s, b_s;
   logic signed [63:0] prod;
   logic [32:0]        a_ext;
   logic [32:0]        trunc_sum, round_sum;
   logic signed [32:0] trunc_shift, round_shift;
   logic [31:0]        b_fix;
   logic [31:0]        a_mag, b_mag;
   logic signed [63:0] mul_sum, mul_shift;

   always_comb begin
      a_s         = $signed(operand_a);
      b_s         = $signed(operand_b);
      prod        = a_s * b_s;
      a_ext       = {operand_a[31], operand_a};
      trunc_sum   = a_ext + (operand_a[31] ? TRUNC_BIAS : 33'd0);
      round_sum   = a_ext + (operand_a[31] ? (ROUND_HALF - 33'd1) : ROUND_HALF);
      trunc_shift = $signed(trunc_sum) >>> FRACTION_BITS;
      round_shift = $signed(round_sum) >>> FRACTION_BITS;
      b_fix       = operand_b << FRACTION_BITS;
      a_mag       = operand_a[31] ? (32'd0 - operand_a) : operand_a;
      b_mag       = operand_b[31] ? (32'd0 - operand_b) : operand_b;

      stage_a_in          = '0;
      stage_a_in.valid    = accept;
      stage_a_in.action   = action_type'(action);
      stage_a_in.product  = prod;
      stage_a_in.neg      = operand_a[31] ^ operand_b[31];
      stage_a_in.divisor  = b_mag;
      case (action_type'(action))
         ACT_INT_TO_FIX:       stage_a_in.simple = b_fix;
         ACT_FIX_TO_INT_TRUNC: stage_a_in.simple = trunc_shift[31:0];
         ACT_FIX_TO_INT_ROUND: stage_a_in.simple = round_shift[31:0];
         ACT_ADD_FF:           stage_a_in.simple = operand_a + operand_b;
         ACT_ADD_FI:           stage_a_in.simple = operand_a + b_fix;
         ACT_SUB_FF:           stage_a_in.simple = operand_a - operand_b;
         ACT_SUB_FI:           stage_a_in.simple = operand_a - b_fix;
         ACT_DIV_FF: begin
            stage_a_in.is_div   = 1'b1;
            stage_a_in.dz       = (operand_b == 32'd0);
            stage_a_in.dividend = DIVIDEND_W'(a_mag) << FRACTION_BITS;
         end
         ACT_DIV_FI: begin
            stage_a_in.is_div   = 1'b1;
            stage_a_in.dz       = (operand_b == 32'd0);
            stage_a_in.dividend = DIVIDEND_W'(a_mag);
         end
         default:              stage_a_in.simple = '0;
      endcase
   end

   always_comb begin
      mul_sum   = stage_a_ff.product +
                  $signed(stage_a_ff.product[63] ? MUL_BIAS : 64'd0);
      mul_shift = mul_sum >>> FRACTION_BITS;

      stage_b_in          = '0;
      stage_b_in.valid    = stage_a_ff.valid;
      stage_b_in.is_div   = stage_a_ff.is_div;
      stage_b_in.neg      = stage_a_ff.neg;
      stage_b_in.dz       = stage_a_ff.dz;
      stage_b_in.dividend = stage_a_ff.dividend;
      stage_b_in.divisor  = stage_a_ff.divisor;
      case (stage_a_ff.action)
         ACT_MUL_FF: stage_b_in.value = mul_shift[31:0];
         ACT_MUL_FI: stage_b_in.value = stage_a_ff.product[31:0];
         default:    stage_b_in.value = stage_a_ff.simple;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_ff.valid <= 1'b0;
         stage_b_ff.valid <= 1'b0;
      end else begin
         stage_a_ff <= stage_a_in;
         stage_b_ff <= stage_b_in;
      end
   end

   assign cell_out = stage_b_ff;

endmodule

[hdl/fpalu_cell.sv]
// ----------------------------------------------------------------------------
// fpalu_cell
// One restoring division step: shifts in a dividend bit, trial-subtracts the
// divisor and appends one quotient bit; other request data rides along.
// ----------------------------------------------------------------------------
module fpalu_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  fpalu_pkg::cell_data_type cell_in,
   output fpalu_pkg::cell_data_type cell_out
);
   import fpalu_pkg::*;

   cell_data_type data_ff, data_in;
   logic [32:0]   trial;
   logic [33:0]   diff;
   logic          take;

   always_comb begin
      trial = {cell_in.rem, cell_in.dividend[DIVIDEND_W-1]};
      diff  = {1'b0, trial} - {2'b00, cell_in.divisor};
      take  = !diff[33];

      data_in          = cell_in;
      data_in.dividend = cell_in.dividend << 1;
      data_in.rem      = take ? diff[31:0] : trial[31:0];
      data_in.quot     = {cell_in.quot[DATA_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign cell_out = data_ff;

endmodule

[hdl/fixed_point_17_14_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu
// Each request passes the front stages in fpalu_prep, the chain of division cells
// and the output register; every action takes the same path to the result strobe.
// Throughput: one request per cycle; busy stays low, the chain of division
// cells (one quotient bit each) moves every cycle and results cannot stall.
// Reset clears every valid bit in the pipeline; requests in flight are lost.
// ----------------------------------------------------------------------------
module fixed_point_17_14_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_action,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_value,
   output logic        rsp_divide_by_zero
);
   import fpalu_pkg::*;

   cell_data_type chain [0:DIVIDEND_W];
   logic          accept;
   logic          valid_ff, valid_in;
   logic [31:0]   value_ff, value_in;
   logic          dz_ff, dz_in;
   logic [31:0]   quot_signed;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   fpalu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .cell_out  (chain[0])
   );

   for (genvar i = 0; i < DIVIDEND_W; i++) begin : g_cell
      fpalu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   always_comb begin
      quot_signed = chain[DIVIDEND_W].neg ? (32'd0 - chain[DIVIDEND_W].quot)
                                          : chain[DIVIDEND_W].quot;
      valid_in    = chain[DIVIDEND_W].valid;
      dz_in       = chain[DIVIDEND_W].valid && chain[DIVIDEND_W].is_div &&
                    chain[DIVIDEND_W].dz;
      if (chain[DIVIDEND_W].is_div) begin
         value_in = chain[DIVIDEND_W].dz ? 32'd0 : quot_signed;
      end else begin
         value_in = chain[DIVIDEND_W].value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dz_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         dz_ff    <= dz_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_value   = value_ff;
   assign rsp_divide_by_zero = dz_ff;

   // every accepted request comes out exactly once, as a result strobe
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LATENCY + 1) rsp_valid)
      else $error("request lost in pipeline");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY + 1))
      else $error("result without request");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_divide_by_zero |-> (rsp_valid && rsp_result_value == 32'd0))
      else $error("divide by zero result not zero");

   a_dz_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_divide_by_zero |-> $past(req_operand_b == 32'd0 &&
         (req_action == ACT_DIV_FF || req_action == ACT_DIV_FI), LATENCY + 1))
      else $error("divide by zero flag without zero divisor");

endmodule
